@@ src/msl_pkg.sv @@
// ----------------------------------------------------------------------------
// Message link supervisor package
// Shared codes, reset values and the supervisor state record.
// ----------------------------------------------------------------------------
package msl_pkg;

	localparam int unsigned LIMIT_W   = 16;
	localparam int unsigned SEQ_W     = 4;
	localparam int unsigned GAP_W     = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [1:0] ACT_TICK   = 2'd0;
	localparam logic [1:0] ACT_FRAME  = 2'd1;
	localparam logic [1:0] ACT_INJECT = 2'd2;

	localparam logic [1:0] LINK_OK       = 2'd0;
	localparam logic [1:0] LINK_DEGRADED = 2'd1;
	localparam logic [1:0] LINK_LOST     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_DEGRADE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_LIMIT    = 2'd1;

	localparam logic [LIMIT_W-1:0] DEGRADE_LIMIT_RST = 16'd300;
	localparam logic [LIMIT_W-1:0] LOST_LIMIT_RST    = 16'd1000;

	typedef struct packed {
		logic               have_frame;
		logic [SEQ_W-1:0]   prev_seq;
		logic [LIMIT_W-1:0] since_good;
		logic [GAP_W-1:0]   gap_count;
	} msl_state_t;

endpackage

@@ src/msl_eval.sv @@
// ----------------------------------------------------------------------------
// Message link supervisor evaluation
// Next supervisor state and link state for one item.
// ----------------------------------------------------------------------------
module msl_eval import msl_pkg::*; (
	input  msl_state_t         cur,
	input  logic [1:0]         action,
	input  logic               frame_valid,
	input  logic [SEQ_W-1:0]   frame_seq,
	input  logic [LIMIT_W-1:0] degrade_limit,
	input  logic [LIMIT_W-1:0] lost_limit,
	output msl_state_t         nxt,
	output logic [1:0]         link_state
);

	logic take;
	logic check;

	always_comb begin
		nxt   = cur;
		take  = 1'b0;
		check = 1'b0;
		unique case (action)
			ACT_TICK: begin
				if (cur.since_good != '1) begin
					nxt.since_good = cur.since_good + LIMIT_W'(1);
				end
			end
			ACT_FRAME: begin
				take  = frame_valid;
				check = frame_valid;
			end
			ACT_INJECT: begin
				take = 1'b1;
			end
			default: begin
			end
		endcase
		if (take) begin
			// The expected sequence wraps modulo the sequence width.
			if (check && cur.have_frame && (frame_seq != cur.prev_seq + SEQ_W'(1))) begin
				nxt.gap_count = cur.gap_count + GAP_W'(1);
			end
			nxt.prev_seq   = frame_seq;
			nxt.have_frame = 1'b1;
			nxt.since_good = '0;
		end
	end

	always_comb begin
		priority if (!nxt.have_frame || nxt.since_good >= lost_limit) begin
			link_state = LINK_LOST;
		end else if (nxt.since_good >= degrade_limit) begin
			link_state = LINK_DEGRADED;
		end else begin
			link_state = LINK_OK;
		end
	end

endmodule

@@ src/message_link_supervisor.sv @@
// ----------------------------------------------------------------------------
// Message link supervisor
// Path: an accepted item passes the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled; the state
// update sits between the input register and the result register.
// Reset: clears both stages and the supervisor state; limits return to
// 300 ms and 1000 ms.
// ----------------------------------------------------------------------------
module message_link_supervisor import msl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  logic                 frame_valid,
	input  logic [SEQ_W-1:0]     frame_seq,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           link_state,
	output logic                 seen_frame,
	output logic [LIMIT_W-1:0]   elapsed_ms,
	output logic [GAP_W-1:0]     lost_frames
);

	logic [LIMIT_W-1:0] degrade_limit_q;
	logic [LIMIT_W-1:0] lost_limit_q;
	msl_state_t         state_q;
	msl_state_t         state_nxt;
	logic [1:0]         link_nxt;

	logic               valid_s1;
	logic [1:0]         action_s1;
	logic               frame_valid_s1;
	logic [SEQ_W-1:0]   frame_seq_s1;

	logic               valid_s2;
	logic [1:0]         link_state_s2;
	logic               seen_frame_s2;
	logic [LIMIT_W-1:0] elapsed_s2;
	logic [GAP_W-1:0]   lost_frames_s2;

	logic out_free;
	logic adv_s1;
	logic load_s1;

	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degrade_limit_q <= DEGRADE_LIMIT_RST;
			lost_limit_q    <= LOST_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEGRADE_LIMIT: degrade_limit_q <= cfg_data;
				REG_LOST_LIMIT:    lost_limit_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			action_s1      <= action;
			frame_valid_s1 <= frame_valid;
			frame_seq_s1   <= frame_seq;
		end
	end

	msl_eval u_eval (
		.cur           (state_q),
		.action        (action_s1),
		.frame_valid   (frame_valid_s1),
		.frame_seq     (frame_seq_s1),
		.degrade_limit (degrade_limit_q),
		.lost_limit    (lost_limit_q),
		.nxt           (state_nxt),
		.link_state    (link_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			link_state_s2  <= link_nxt;
			seen_frame_s2  <= state_nxt.have_frame;
			elapsed_s2     <= state_nxt.since_good;
			lost_frames_s2 <= state_nxt.gap_count;
		end
	end

	assign out_valid   = valid_s2;
	assign link_state  = link_state_s2;
	assign seen_frame  = seen_frame_s2;
	assign elapsed_ms  = elapsed_s2;
	assign lost_frames = lost_frames_s2;

	// Once a frame has been taken the link never returns to the no-frame case.
	a_seen_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.have_frame |=> state_q.have_frame)
		else $error("seen flag dropped");

	// Without any frame the reported state must be lost.
	a_no_frame_lost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_frame |-> link_state == LINK_LOST)
		else $error("link not lost before first frame");

	// The gap counter moves by at most one per item.
	a_gap_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.gap_count != $past(state_q.gap_count) |->
			state_q.gap_count == $past(state_q.gap_count) + GAP_W'(1))
		else $error("gap counter jumped");

	// The state changes only when an item leaves the input register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(state_q))
		else $error("state changed without an item");

endmodule
